>>> rtl/core/tir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tir_pkg
// Shared widths and constants of the trapezoid integral block.
// ----------------------------------------------------------------------------
package tir_pkg;

    localparam int MAX_SEGMENTS_DEF  = 1024;
    localparam int FRACTION_BITS_DEF = 30;

    localparam int BOUND_W = 8;    // integer bounds
    localparam int COUNT_W = 11;   // segment count
    localparam int VALUE_W = 48;   // integrand, terms, sum
    localparam int X_W     = 25;   // Q8.16 grid point and step, signed
    localparam int HNUM_W  = 24;   // |b - a| * 2^16
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DEN_W   = 56;   // 8 - x^3 in Q.32, signed

    localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [DEN_W-1:0]   DEN_EIGHT = DEN_W'(64'd1 << 35);

endpackage
`default_nettype wire

>>> rtl/core/tir_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tir_if
// Request and result channels of the trapezoid integral block.
// ----------------------------------------------------------------------------
interface tir_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [tir_pkg::BOUND_W-1:0] lower_bound;
    logic signed [tir_pkg::BOUND_W-1:0] upper_bound;
    logic        [tir_pkg::COUNT_W-1:0] segment_count;

    modport source (output valid, lower_bound, upper_bound, segment_count, input ready);
    modport sink   (input valid, lower_bound, upper_bound, segment_count, output ready);
endinterface

interface tir_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [tir_pkg::VALUE_W-1:0] integral_value;
    logic                               pole_hit;
    logic                               saturated;

    modport source (output valid, integral_value, pole_hit, saturated, input ready);
    modport sink   (input valid, integral_value, pole_hit, saturated, output ready);
endinterface
`default_nettype wire

>>> rtl/core/trapezoid_integral_rational_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trapezoid_integral_rational_top
// Trapezoidal-rule integral of 1/(8 - x^3) over [a, b] in n segments.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                      Transfer
// i_in     in   lower_bound, upper_bound, segment_count      valid & ready
// o_out    out  integral_value, pole_hit, saturated          valid & ready
//
// Each grid point takes up to FRACTION_BITS+32 steps of the serial reciprocal
// divider (fewer when the quotient clips, none at a pole); that divider sets
// the rate. A zero count goes straight to the result. The step h comes from
// a 24-step restoring divider; one 25x24 multiplier is shared by the cube and
// the trapezoid terms. Ready is high only when idle. Reset is synchronous,
// active low. A stalled result holds.
// ----------------------------------------------------------------------------
module trapezoid_integral_rational_top #(
    parameter int MAX_SEGMENTS  = tir_pkg::MAX_SEGMENTS_DEF,
    parameter int FRACTION_BITS = tir_pkg::FRACTION_BITS_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    tir_in_if.sink    i_in,
    tir_out_if.source o_out
);

    localparam int DIV_STEPS = FRACTION_BITS + 32;
    localparam int K_W       = $clog2(DIV_STEPS);
    localparam int VW        = tir_pkg::VALUE_W;
    localparam int XW        = tir_pkg::X_W;
    localparam int CW        = tir_pkg::COUNT_W;
    localparam int PW        = tir_pkg::MUL_P_W;
    localparam int DW        = tir_pkg::DEN_W;

    typedef enum logic [3:0] {
        S_IDLE, S_HDIV, S_SQ, S_C1, S_C2, S_C3, S_DIV, S_POST,
        S_T1, S_T2, S_T3, S_OUT
    } t_state;

    t_state r_state;

    logic [CW-1:0]                   r_n, r_idx;
    logic [tir_pkg::HNUM_W-1:0]      r_num;
    logic [CW:0]                     r_rem;
    logic                            r_hneg;
    logic signed [XW-1:0]            r_x, r_h;
    logic [K_W-1:0]                  r_k;
    logic [PW-1:0]                   r_prod, r_p1;
    logic [23:0]                     r_lo;
    logic [DW-1:0]                   r_dd;
    logic [DW:0]                     r_r;
    logic [VW-1:0]                   r_q;
    logic                            r_dneg;
    logic signed [VW-1:0]            r_f, r_prev, r_sum;
    logic                            r_first, r_neg, r_pole, r_sat;

    // ---- operand magnitudes
    logic [XW-1:0] n_xneg, n_hneg_v;
    logic [23:0]   n_m, n_hm;
    assign n_xneg   = -r_x;
    assign n_hneg_v = -r_h;
    assign n_m  = r_x[XW-1] ? n_xneg[23:0] : r_x[23:0];
    assign n_hm = r_h[XW-1] ? n_hneg_v[23:0] : r_h[23:0];

    // ---- trapezoid pair sum
    logic signed [VW:0] n_s;
    logic [VW:0]        n_sneg, n_sm;
    assign n_s    = {r_prev[VW-1], r_prev} + {r_f[VW-1], r_f};
    assign n_sneg = -n_s;
    assign n_sm   = n_s[VW] ? n_sneg : n_s;

    // ---- shared multiplier
    logic [tir_pkg::MUL_A_W-1:0] n_mul_a;
    logic [tir_pkg::MUL_B_W-1:0] n_mul_b;
    logic [PW-1:0]               n_mul_p;
    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        case (r_state)
            S_SQ: begin
                n_mul_a = {1'b0, n_m};
                n_mul_b = n_m;
            end
            S_C1: begin
                n_mul_a = tir_pkg::MUL_A_W'(r_prod[47:32]);
                n_mul_b = n_m;
            end
            S_C2: begin
                n_mul_a = {1'b0, r_lo};
                n_mul_b = n_m;
            end
            S_T1: begin
                n_mul_a = n_sm[VW:24];
                n_mul_b = n_hm;
            end
            S_T2: begin
                n_mul_a = {1'b0, r_lo};
                n_mul_b = n_hm;
            end
            default: ;
        endcase
    end
    assign n_mul_p = PW'(n_mul_a) * PW'(n_mul_b);

    // ---- cube and denominator
    logic [72:0]   n_cube_sum;
    logic [53:0]   n_cube;
    logic [DW-1:0] n_den, n_den_neg, n_den_mag;
    assign n_cube_sum = {r_p1, 24'b0} + 73'(r_prod);
    assign n_cube     = n_cube_sum[61:8];
    assign n_den      = r_x[XW-1] ? (tir_pkg::DEN_EIGHT + DW'(n_cube))
                                  : (tir_pkg::DEN_EIGHT - DW'(n_cube));
    assign n_den_neg  = -n_den;
    assign n_den_mag  = n_den[DW-1] ? n_den_neg : n_den;

    // ---- reciprocal divider step
    logic [DW:0]   n_r2, n_rn;
    logic          n_ge;
    logic [VW-1:0] n_qn, n_qneg;
    assign n_r2  = {r_r[DW-1:0], 1'b0};
    assign n_ge  = n_r2 >= {1'b0, r_dd};
    assign n_rn  = n_ge ? (n_r2 - {1'b0, r_dd}) : n_r2;
    assign n_qn  = {r_q[VW-2:0], n_ge};
    assign n_qneg = -n_qn;

    // ---- step divider
    logic [CW:0]                n_rem2, n_remn;
    logic                       n_hge;
    logic [tir_pkg::HNUM_W-1:0] n_hq;
    logic [XW-1:0]              n_hq_ext;
    assign n_rem2   = {r_rem[CW-1:0], r_num[tir_pkg::HNUM_W-1]};
    assign n_hge    = n_rem2 >= {1'b0, r_n};
    assign n_remn   = n_hge ? (n_rem2 - {1'b0, r_n}) : n_rem2;
    assign n_hq     = {r_num[tir_pkg::HNUM_W-2:0], n_hge};
    assign n_hq_ext = {1'b0, n_hq};

    // ---- term and accumulate
    logic [56:0]          n_t;
    logic                 n_tclip;
    logic [VW-1:0]        n_tm, n_tv;
    logic signed [VW:0]   n_acc;
    assign n_t     = 57'({r_p1, 7'b0}) + 57'(r_prod[PW-1:17]);
    assign n_tclip = n_t > 57'(tir_pkg::VAL_MAX);
    assign n_tm    = n_tclip ? tir_pkg::VAL_MAX : n_t[VW-1:0];
    assign n_tv    = r_neg ? -n_tm : n_tm;
    assign n_acc   = {r_sum[VW-1], r_sum} + {n_tv[VW-1], n_tv};

    // ---- request decode
    localparam int BW_D = tir_pkg::BOUND_W + 1;
    logic signed [BW_D-1:0] n_diff;
    logic [BW_D-1:0] n_diff_neg;
    logic [CW-1:0]   n_ncl;
    assign n_diff = {i_in.upper_bound[tir_pkg::BOUND_W-1], i_in.upper_bound}
                  - {i_in.lower_bound[tir_pkg::BOUND_W-1], i_in.lower_bound};
    assign n_diff_neg = -n_diff;
    always_comb begin
        if (32'(i_in.segment_count) > 32'(MAX_SEGMENTS)) begin
            n_ncl = CW'(MAX_SEGMENTS);
        end else begin
            n_ncl = i_in.segment_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_n     <= n_ncl;
                        r_idx   <= '0;
                        r_sum   <= '0;
                        r_pole  <= 1'b0;
                        r_sat   <= 1'b0;
                        r_first <= 1'b1;
                        r_rem   <= '0;
                        r_k     <= '0;
                        r_hneg  <= n_diff[BW_D-1];
                        r_num   <= {(n_diff[BW_D-1] ? n_diff_neg[7:0] : n_diff[7:0]), 16'b0};
                        r_x     <= {i_in.lower_bound[tir_pkg::BOUND_W-1],
                                    i_in.lower_bound, 16'b0};
                        r_state <= (n_ncl == '0) ? S_OUT : S_HDIV;
                    end
                end
                S_HDIV: begin
                    r_rem <= n_remn;
                    r_num <= n_hq;
                    if (r_k == K_W'(tir_pkg::HNUM_W - 1)) begin
                        r_h     <= r_hneg ? -n_hq_ext : n_hq_ext;
                        r_state <= S_SQ;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_SQ: begin
                    r_prod  <= n_mul_p;
                    r_state <= S_C1;
                end
                S_C1: begin
                    r_lo    <= r_prod[31:8];
                    r_prod  <= n_mul_p;
                    r_state <= S_C2;
                end
                S_C2: begin
                    r_p1    <= r_prod;
                    r_prod  <= n_mul_p;
                    r_state <= S_C3;
                end
                S_C3: begin
                    if (n_den == '0) begin
                        // pole: saturate the sample
                        r_f     <= tir_pkg::VAL_MAX;
                        r_pole  <= 1'b1;
                        r_sat   <= 1'b1;
                        r_state <= S_POST;
                    end else begin
                        r_dd    <= n_den_mag;
                        r_dneg  <= n_den[DW-1];
                        r_r     <= (DW+1)'(1);
                        r_q     <= '0;
                        r_k     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_r <= n_rn;
                    r_q <= n_qn;
                    r_k <= r_k + 1'b1;
                    if (n_qn[VW-1]) begin
                        r_f     <= r_dneg ? -tir_pkg::VAL_MAX : tir_pkg::VAL_MAX;
                        r_sat   <= 1'b1;
                        r_state <= S_POST;
                    end else if (r_k == K_W'(DIV_STEPS - 1)) begin
                        r_f     <= r_dneg ? n_qneg : n_qn;
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_prev  <= r_f;
                        r_idx   <= r_idx + 1'b1;
                        r_x     <= r_x + r_h;
                        r_state <= S_SQ;
                    end else begin
                        r_state <= S_T1;
                    end
                end
                S_T1: begin
                    r_prod  <= n_mul_p;
                    r_lo    <= n_sm[23:0];
                    r_neg   <= n_s[VW] != r_h[XW-1];
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_p1    <= r_prod;
                    r_prod  <= n_mul_p;
                    r_state <= S_T3;
                end
                S_T3: begin
                    if (n_acc > $signed({tir_pkg::VAL_MAX[VW-1], tir_pkg::VAL_MAX})) begin
                        r_sum <= tir_pkg::VAL_MAX;
                        r_sat <= 1'b1;
                    end else if (n_acc < $signed({1'b1, tir_pkg::VAL_MIN})) begin
                        r_sum <= tir_pkg::VAL_MIN;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= n_acc[VW-1:0];
                        if (n_tclip) begin
                            r_sat <= 1'b1;
                        end
                    end
                    r_prev <= r_f;
                    if (r_idx == r_n) begin
                        r_state <= S_OUT;
                    end else begin
                        // advance to the next grid point
                        r_idx   <= r_idx + 1'b1;
                        r_x     <= r_x + r_h;
                        r_state <= S_SQ;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = (r_state == S_OUT);
    assign o_out.integral_value = r_sum;
    assign o_out.pole_hit       = r_pole;
    assign o_out.saturated      = r_sat;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("request taken while a result is pending");

    a_pole_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.pole_hit) |-> o_out.saturated)
        else $error("pole without saturated flag");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("ready right after a request transfer");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ || r_state == S_T3) |-> (r_idx <= r_n))
        else $error("grid index past segment count");

endmodule
`default_nettype wire

>>> verif/tb_trapezoid_integral_rational_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trapezoid_integral_rational_top
// Self-checking bench for the trapezoid integral block: requests are driven
// from a queue with random gaps, each accepted request is evaluated by a
// fixed-point integral predictor, and each result transfer is checked
// against the oldest predicted integral.
// ----------------------------------------------------------------------------
module tb_trapezoid_integral_rational_top;

    localparam int              FRAC_BITS = tir_pkg::FRACTION_BITS_DEF;
    localparam int              SEG_MAX   = tir_pkg::MAX_SEGMENTS_DEF;
    localparam longint          SUM_HI    = (64'sd1 <<< 47) - 1;
    localparam longint          SUM_LO    = -SUM_HI - 1;
    localparam longint unsigned SUM_HI_U  = (64'd1 << 47) - 1;
    localparam int              STALL_LIMIT = 400000;
    localparam int              CALM_TAIL   = 20;

    typedef struct packed {
        logic signed [tir_pkg::BOUND_W-1:0] lower_bound;
        logic signed [tir_pkg::BOUND_W-1:0] upper_bound;
        logic        [tir_pkg::COUNT_W-1:0] segment_count;
        logic                               drain_first;
    } t_request;

    typedef struct packed {
        logic signed [tir_pkg::VALUE_W-1:0] integral_value;
        logic                               pole_hit;
        logic                               saturated;
    } t_integral;

    logic i_clk;
    logic i_rst_n;

    tir_in_if  in_ch ();
    tir_out_if out_ch ();

    trapezoid_integral_rational_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_request  pending_requests[$];
    t_integral expected_integrals[$];

    bit pole_seen;
    bit clip_seen;
    bit req_fire;
    int send_gap;
    int recv_stall;
    int mismatch_count;
    int checked_count;
    int pole_count;
    int sat_count;
    int idle_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // 1/(8 - x^3) with x in Q8.16, FRAC_BITS fraction bits out
    function automatic longint integrand_q(longint x);
        longint unsigned m, sq, cube, d, r, q;
        longint          cube_s, den;
        int              k;
        bit              clip;
        m      = (x < 0) ? -x : x;
        sq     = m * m;
        cube   = ((sq >> 8) * m) >> 8;
        cube_s = (x < 0) ? -longint'(cube) : longint'(cube);
        den    = (64'sd8 <<< 32) - cube_s;
        if (den == 0) begin
            pole_seen = 1'b1;
            clip_seen = 1'b1;
            return SUM_HI;
        end
        d    = (den < 0) ? -den : den;
        r    = 1;
        q    = 0;
        clip = 1'b0;
        for (k = 0; k < FRAC_BITS + 32 && !clip; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
            if (q > SUM_HI_U) clip = 1'b1;
        end
        if (clip) begin
            q = SUM_HI_U;
            clip_seen = 1'b1;
        end
        return (den < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint trapezoid_area(longint f0, longint f1, longint h);
        longint          s;
        longint unsigned sm, hm, t;
        bit              neg;
        s   = f0 + f1;
        sm  = (s < 0) ? -s : s;
        hm  = (h < 0) ? -h : h;
        t   = (((sm >> 24) * hm) << 7) + (((sm & 64'hFFFFFF) * hm) >> 17);
        neg = (s < 0) != (h < 0);
        if (t > SUM_HI_U) begin
            t = SUM_HI_U;
            clip_seen = 1'b1;
        end
        return neg ? -longint'(t) : longint'(t);
    endfunction

    function automatic t_integral predict_integral(t_request req);
        longint    a, b, h, x, f_prev, f_next, acc, total;
        int        n, i;
        t_integral res;
        a         = req.lower_bound;
        b         = req.upper_bound;
        n         = int'(req.segment_count);
        pole_seen = 1'b0;
        clip_seen = 1'b0;
        total     = 0;
        if (n > SEG_MAX) n = SEG_MAX;
        if (n != 0) begin
            h      = ((b - a) * 65536) / longint'(n);
            f_prev = integrand_q(a * 65536);
            for (i = 1; i <= n; i++) begin
                x      = a * 65536 + h * i;
                f_next = integrand_q(x);
                acc    = total + trapezoid_area(f_prev, f_next, h);
                if (acc > SUM_HI) begin
                    acc = SUM_HI;
                    clip_seen = 1'b1;
                end else if (acc < SUM_LO) begin
                    acc = SUM_LO;
                    clip_seen = 1'b1;
                end
                total  = acc;
                f_prev = f_next;
            end
        end
        res.integral_value = total[tir_pkg::VALUE_W-1:0];
        res.pole_hit       = pole_seen;
        res.saturated      = clip_seen;
        return res;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        t_request req;
        logic     next_valid;
        bit       calm;
        next_valid = in_ch.valid;
        calm = pending_requests.size() < CALM_TAIL;
        if (i_rst_n && !(in_ch.valid && !req_fire)) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain_first &&
                           expected_integrals.size() != 0)) begin
                req = pending_requests.pop_front();
                in_ch.lower_bound   <= req.lower_bound;
                in_ch.upper_bound   <= req.upper_bound;
                in_ch.segment_count <= req.segment_count;
                next_valid = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    send_gap <= $urandom_range(1, 15);
            end
        end
        in_ch.valid <= next_valid;

        if (i_rst_n) begin
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                recv_stall <= $urandom_range(0, 14);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // monitor: predict on request transfer, check on result transfer
    always @(posedge i_clk) begin
        t_request  req;
        t_integral exp_res;
        bit        in_xfer, out_xfer;
        in_xfer  = i_rst_n && in_ch.valid && in_ch.ready;
        out_xfer = i_rst_n && out_ch.valid && out_ch.ready;
        req_fire <= in_xfer;
        if (in_xfer) begin
            req.lower_bound   = in_ch.lower_bound;
            req.upper_bound   = in_ch.upper_bound;
            req.segment_count = in_ch.segment_count;
            req.drain_first   = 1'b0;
            expected_integrals.push_back(predict_integral(req));
        end
        if (out_xfer) begin
            if (expected_integrals.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: value=%0d pole=%0b sat=%0b",
                             out_ch.integral_value, out_ch.pole_hit, out_ch.saturated);
            end else begin
                exp_res = expected_integrals.pop_front();
                checked_count++;
                pole_count += exp_res.pole_hit;
                sat_count  += exp_res.saturated;
                if (out_ch.integral_value !== exp_res.integral_value ||
                    out_ch.pole_hit !== exp_res.pole_hit ||
                    out_ch.saturated !== exp_res.saturated) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d mismatch: exp value=%0d pole=%0b sat=%0b,",
                                  " got value=%0d pole=%0b sat=%0b"},
                                 checked_count, exp_res.integral_value, exp_res.pole_hit,
                                 exp_res.saturated, out_ch.integral_value,
                                 out_ch.pole_hit, out_ch.saturated);
                end
            end
        end
        if (in_xfer || out_xfer || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_trapezoid_integral_rational_top failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_request(int lo, int hi, int n, bit drain);
        t_request req;
        req.lower_bound   = tir_pkg::BOUND_W'(lo);
        req.upper_bound   = tir_pkg::BOUND_W'(hi);
        req.segment_count = tir_pkg::COUNT_W'(n);
        req.drain_first   = drain;
        pending_requests.push_back(req);
    endtask

    initial begin
        int k, lo, hi, n;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.lower_bound   = '0;
        in_ch.upper_bound   = '0;
        in_ch.segment_count = '0;
        out_ch.ready        = 1'b0;
        send_gap            = 0;
        recv_stall          = 0;
        mismatch_count      = 0;
        checked_count       = 0;
        pole_count          = 0;
        sat_count           = 0;
        idle_cycles         = 0;
        req_fire            = 1'b0;

        // directed: extremes, reversed interval, pole, zero and clamped counts
        add_request(0, 1, 1, 0);
        add_request(-128, 127, 1, 0);
        add_request(127, -128, 3, 0);
        add_request(-128, -128, 1, 0);
        add_request(127, 127, 2, 0);
        add_request(0, 4, 2, 0);        // grid point lands on the pole
        add_request(2, 2, 1, 0);
        add_request(4, 0, 4, 1);
        add_request(1, 3, 7, 0);
        add_request(-5, 5, 0, 0);       // no segments
        add_request(-2, 1, 1024, 0);
        add_request(-3, 3, 2047, 1);    // count above the maximum, clamped
        add_request(1, 2, 1365, 0);
        add_request(-1, 1, 682, 0);
        add_request(-128, 1, 16, 0);

        for (k = 0; k < 100; k++) begin
            if ($urandom_range(0, 2) == 0) begin
                lo = $urandom_range(0, 6) - 3;
                hi = $urandom_range(0, 6) - 3;
            end else begin
                lo = $urandom_range(0, 255) - 128;
                hi = $urandom_range(0, 255) - 128;
            end
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 200)
                                             : $urandom_range(1, 32);
            add_request(lo, hi, n, k == 50);
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // hold until every request is sent and every result has come back
        while (pending_requests.size() != 0 || in_ch.valid ||
               expected_integrals.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("checked %0d integrals, %0d with a pole and %0d saturated",
                 checked_count, pole_count, sat_count);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0 && expected_integrals.size() == 0) begin
            $display("tb_trapezoid_integral_rational_top passed");
        end else begin
            $display("tb_trapezoid_integral_rational_top failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/tir_pkg.sv
rtl/core/tir_if.sv
rtl/core/trapezoid_integral_rational_top.sv
verif/tb_trapezoid_integral_rational_top.sv
